>>> hdl/bris_pkg.sv
// Shared types, constants and helpers for the bounded random integer sampler.
`timescale 1ns / 1ps
`default_nettype none
package bris_pkg;
	localparam int WORD_BITS = 32;
	localparam int CNT_W = $clog2(WORD_BITS + 1);
	localparam int IDX_W = 2;

	localparam logic [IDX_W-1:0] IDX_RANGE = IDX_W'(0);
	localparam logic [IDX_W-1:0] IDX_MODE  = IDX_W'(1);

	localparam logic [2:0] MODE_MOD   = 3'd0;
	localparam logic [2:0] MODE_MUL   = 3'd1;
	localparam logic [2:0] MODE_DICE  = 3'd2;
	localparam logic [2:0] MODE_MASK  = 3'd3;
	localparam logic [2:0] MODE_BUF   = 3'd4;
	localparam logic [2:0] MODE_MROLL = 3'd5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_THRESH,
		ST_WORK,
		ST_HOLD
	} state_t;

	typedef struct packed {
		logic cfg_write;
		logic load;
		logic thr_step;
		logic step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic thr_last;
		logic found;
		logic fin;
		logic out_full;
	} status_t;

	function automatic logic [CNT_W-1:0] bit_len(input logic [WORD_BITS-1:0] v);
		logic [CNT_W-1:0] n;
		n = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (v[i]) n = CNT_W'(i + 1);
		end
		return n;
	endfunction
endpackage
`default_nettype wire

>>> hdl/bounded_random_integer_sampler_core.sv
// Top level of the bounded random integer sampler.
// One word in work at a time.
// Modulo mode: one remainder bit per cycle in the shared divider.
// Dice roller modes: one bit of the word per cycle.
// A register write recomputes the threshold in the divider.
// Reset: range 1, multiply-shift mode, no sample in progress, output empty.
`timescale 1ns / 1ps
`default_nettype none
module bounded_random_integer_sampler_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [bris_pkg::IDX_W-1:0]     cfg_index,
	input  wire logic [bris_pkg::WORD_BITS-1:0] cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [bris_pkg::WORD_BITS-1:0] random_word,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [bris_pkg::WORD_BITS-1:0]      sample_value
);
	import bris_pkg::*;

	cmd_t    cmd;
	status_t sts;

	bris_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bris_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.random_word  (random_word),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.sample_value (sample_value),
		.sts          (sts)
	);
endmodule
`default_nettype wire

>>> hdl/bris_ctrl.sv
// Controller state machine of the bounded random integer sampler.
`timescale 1ns / 1ps
`default_nettype none
module bris_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_valid,
	output logic                 cfg_ready,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic            out_ready,
	input  wire bris_pkg::status_t sts,
	output bris_pkg::cmd_t       cmd
);
	import bris_pkg::*;

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_n;
	end

	always_comb begin
		state_n = state_q;
		cmd = '0;
		cfg_ready = 1'b0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cfg_ready = 1'b1;
				in_ready = !cfg_valid;
				if (cfg_valid) begin
					cmd.cfg_write = 1'b1;
					state_n = ST_THRESH;
				end else if (in_valid) begin
					cmd.load = 1'b1;
					state_n = ST_WORK;
				end
			end
			ST_THRESH: begin
				cmd.thr_step = 1'b1;
				if (sts.thr_last) state_n = ST_IDLE;
			end
			ST_WORK: begin
				cmd.step = 1'b1;
				if (sts.found) state_n = ST_HOLD;
				else if (sts.fin) state_n = ST_IDLE;
			end
			ST_HOLD: begin
				if (!sts.out_full || out_ready) begin
					cmd.out_load = 1'b1;
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

>>> hdl/bris_dp.sv
// Datapath of the bounded random integer sampler: divider, multiplier, roller, mask logic.
`timescale 1ns / 1ps
`default_nettype none
module bris_dp (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire bris_pkg::cmd_t                   cmd,
	input  wire logic [bris_pkg::IDX_W-1:0]       cfg_index,
	input  wire logic [bris_pkg::WORD_BITS-1:0]   cfg_data,
	input  wire logic [bris_pkg::WORD_BITS-1:0]   random_word,
	input  wire logic                             out_ready,
	output logic                                  out_valid,
	output logic [bris_pkg::WORD_BITS-1:0]        sample_value,
	output bris_pkg::status_t                     sts
);
	import bris_pkg::*;

	localparam int W = WORD_BITS;

	logic [W-1:0]     range_q, thr_q, word_q, res_q, out_q, cand_q, b_q;
	logic [2:0]       mode_q;
	logic [W:0]       span_q, val_q;
	logic [CNT_W-1:0] k_q, avail_q, pos_q, div_cnt_q;
	logic             started_q, out_valid_q;
	logic [W-1:0]     div_rem_q, div_dvd_q;
	logic [2*W-1:0]   prod_s1;

	logic [W-1:0]     s_eff, mask, rng_new;
	logic [CNT_W-1:0] len;
	logic [W:0]       div_q, div_r;
	logic [W-1:0]     div_rem_n;

	logic [W:0]       span_n, val_n, rv, rs;
	logic [W-1:0]     cand_n, b_n, res_n, c4, lowm;
	logic [CNT_W-1:0] k_n, avail_n, pos_n, need, nb;
	logic             started_n, found, fin;

	assign s_eff = (range_q == '0) ? W'(1) : range_q;
	assign len = bit_len(s_eff);
	assign mask = W'(({1'b0, {W{1'b1}}} >> (CNT_W'(W) - len)));

	assign div_q = {div_rem_q, div_dvd_q[W-1]};
	assign div_r = (div_q >= {1'b0, s_eff}) ? div_q - {1'b0, s_eff} : div_q;
	assign div_rem_n = div_r[W-1:0];

	always_comb begin
		span_n = span_q;
		val_n = val_q;
		cand_n = cand_q;
		k_n = k_q;
		b_n = b_q;
		avail_n = avail_q;
		pos_n = pos_q + CNT_W'(1);
		started_n = started_q;
		res_n = res_q;
		found = 1'b0;
		fin = 1'b0;
		rv = '0;
		rs = '0;
		need = '0;
		nb = '0;
		lowm = '0;
		c4 = '0;
		case (mode_q)
			MODE_MOD: begin
				if (word_q < thr_q) fin = 1'b1;
				else if (div_cnt_q == CNT_W'(1)) begin
					found = 1'b1;
					res_n = div_rem_n;
				end
			end
			MODE_MUL: begin
				if (pos_q != '0) begin
					if (prod_s1[W-1:0] >= thr_q) begin
						found = 1'b1;
						res_n = prod_s1[2*W-1:W];
					end else fin = 1'b1;
				end
			end
			MODE_MASK: begin
				if ((word_q & mask) < s_eff) begin
					found = 1'b1;
					res_n = word_q & mask;
				end else fin = 1'b1;
			end
			MODE_BUF: begin
				need = len - k_q;
				nb = (need < avail_q) ? need : avail_q;
				lowm = W'(({1'b0, {W{1'b1}}} >> (CNT_W'(W) - nb)));
				c4 = cand_q | ((b_q & lowm) << k_q);
				b_n = b_q >> nb;
				avail_n = avail_q - nb;
				k_n = k_q + nb;
				cand_n = c4;
				if (k_n == len) begin
					if (c4 < s_eff) begin
						found = 1'b1;
						res_n = c4;
					end else begin
						cand_n = '0;
						k_n = '0;
					end
				end
				if (!found && avail_n == '0) fin = 1'b1;
			end
			MODE_DICE, MODE_MROLL: begin
				if (mode_q == MODE_MROLL && !started_q) begin
					if ((word_q & mask) < s_eff) begin
						found = 1'b1;
						res_n = word_q & mask;
					end else begin
						span_n = {1'b0, mask} + (W+1)'(1) - {1'b0, s_eff};
						val_n = {1'b0, (word_q & mask) - s_eff};
						started_n = 1'b1;
						pos_n = len;
						if (len == CNT_W'(W)) fin = 1'b1;
					end
				end else begin
					rv = {val_q[W-1:0], word_q[pos_q[CNT_W-2:0]]};
					rs = {span_q[W-1:0], 1'b0};
					span_n = rs;
					val_n = rv;
					if (rs >= {1'b0, s_eff}) begin
						if (rv < {1'b0, s_eff}) begin
							found = 1'b1;
							res_n = rv[W-1:0];
						end else begin
							span_n = rs - {1'b0, s_eff};
							val_n = rv - {1'b0, s_eff};
						end
					end
					if (!found && pos_q == CNT_W'(W - 1)) fin = 1'b1;
				end
			end
			default: fin = 1'b1;
		endcase
	end

	assign rng_new = (cfg_index == IDX_RANGE) ? cfg_data : range_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q <= W'(1);
			mode_q <= MODE_MUL;
			thr_q <= '0;
			span_q <= (W+1)'(1);
			val_q <= '0;
			cand_q <= '0;
			k_q <= '0;
			started_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cfg_write && (cfg_index == IDX_RANGE || cfg_index == IDX_MODE)) begin
				range_q <= rng_new;
				if (cfg_index == IDX_MODE) mode_q <= cfg_data[2:0];
				span_q <= (W+1)'(1);
				val_q <= '0;
				cand_q <= '0;
				k_q <= '0;
				started_q <= 1'b0;
			end
			if (cmd.thr_step && div_cnt_q == CNT_W'(1)) thr_q <= div_rem_n;
			if (cmd.load && !started_q && (mode_q == MODE_DICE || mode_q == MODE_BUF)) begin
				started_q <= 1'b1;
				span_q <= (W+1)'(1);
				val_q <= '0;
				cand_q <= '0;
				k_q <= '0;
			end
			if (cmd.step) begin
				if (found) begin
					span_q <= (W+1)'(1);
					val_q <= '0;
					cand_q <= '0;
					k_q <= '0;
					started_q <= 1'b0;
				end else begin
					span_q <= span_n;
					val_q <= val_n;
					cand_q <= cand_n;
					k_q <= k_n;
					started_q <= started_n;
				end
			end
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cfg_write) begin
			div_dvd_q <= W'(0) - ((rng_new == '0) ? W'(1) : rng_new);
			div_rem_q <= '0;
			div_cnt_q <= CNT_W'(W);
		end
		if (cmd.load) begin
			word_q <= random_word;
			b_q <= random_word;
			avail_q <= CNT_W'(W);
			pos_q <= '0;
			div_dvd_q <= random_word;
			div_rem_q <= '0;
			div_cnt_q <= CNT_W'(W);
		end
		if (cmd.thr_step || (cmd.step && mode_q == MODE_MOD)) begin
			div_rem_q <= div_rem_n;
			div_dvd_q <= div_dvd_q << 1;
			div_cnt_q <= div_cnt_q - CNT_W'(1);
		end
		if (cmd.step) begin
			pos_q <= pos_n;
			b_q <= b_n;
			avail_q <= avail_n;
			res_q <= res_n;
			prod_s1 <= word_q * s_eff;
		end
		if (cmd.out_load) out_q <= res_q;
	end

	assign out_valid = out_valid_q;
	assign sample_value = out_q;
	assign sts.thr_last = (div_cnt_q == CNT_W'(1));
	assign sts.found = found;
	assign sts.fin = fin;
	assign sts.out_full = out_valid_q;
endmodule
`default_nettype wire

>>> hdl/bris_checker.sv
// Port-level checker for the bounded random integer sampler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module bris_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           cfg_valid,
	input wire logic                           cfg_ready,
	input wire logic                           in_valid,
	input wire logic                           in_ready,
	input wire logic                           out_valid,
	input wire logic                           out_ready,
	input wire logic [bris_pkg::WORD_BITS-1:0] sample_value
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_value))
		else $error("result dropped or changed while stalled");

	a_cfg_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !in_ready && !cfg_ready)
		else $error("transaction taken during threshold update");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word taken while one is in work");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_valid && in_ready && cfg_valid && cfg_ready))
		else $error("input and register write in the same cycle");
endmodule

bind bounded_random_integer_sampler_core bris_checker u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.sample_value (sample_value)
);
`default_nettype wire
